// File: rtl/mcvt_pkg.sv
package mcvt_pkg;

    localparam int CC_COUNT      = 128;
    localparam int NRPN_COUNT    = 16384;
    localparam int TABLE_SIZE    = CC_COUNT + NRPN_COUNT;
    localparam int FRACTION_BITS = 16;

    localparam logic [13:0] MAX_CC     = 14'd127;
    localparam logic [13:0] MAX_NRPN   = 14'd16383;
    localparam logic [13:0] CC_RESET   = 14'd63;
    localparam logic [13:0] NRPN_RESET = 14'd8191;
    localparam logic [13:0] WHEEL_CTR  = 14'd8192;

    // operation codes
    localparam logic [2:0] OP_CONV_IN  = 3'd0;
    localparam logic [2:0] OP_MEASURE  = 3'd1;
    localparam logic [2:0] OP_CONV_OUT = 3'd2;
    localparam logic [2:0] OP_CENTER   = 3'd3;
    localparam logic [2:0] OP_SET      = 3'd4;

    // message kinds
    localparam logic [2:0] KIND_WHEEL    = 3'd0;
    localparam logic [2:0] KIND_CC       = 3'd1;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd2;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd3;

    // encoding methods
    localparam logic [1:0] METH_ABS     = 2'd0;
    localparam logic [1:0] METH_BINOFF  = 2'd1;
    localparam logic [1:0] METH_SIGNMAG = 2'd2;
    localparam logic [1:0] METH_TWOS    = 2'd3;

    // configuration register indexes
    localparam logic CFG_WHEEL_MIN = 1'b0;
    localparam logic CFG_WHEEL_MAX = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  msg_kind;
        logic [14:0] idx;
        logic [13:0] value;
        logic [16:0] frac;
        logic        wrap;
        logic [1:0]  method;
        logic [13:0] low;
        logic [13:0] high;
        logic        idx_ok;
        logic        nrpn;
    } t_cmd;

    typedef struct packed {
        logic [13:0] lo;
        logic [13:0] hi;
        logic [1:0]  meth;
        logic [13:0] pos;
    } t_entry;

endpackage

// File: rtl/mcvt_if.sv
interface mcvt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [2:0]  msg_kind;
    logic [14:0] control_index;
    logic [13:0] midi_value;
    logic [16:0] fraction_in;
    logic        wrap_mode;
    logic [1:0]  new_method;
    logic [13:0] new_low;
    logic [13:0] new_high;

    modport source (
        output valid, opcode, msg_kind, control_index, midi_value, fraction_in,
               wrap_mode, new_method, new_low, new_high,
        input  ready
    );
    modport sink (
        input  valid, opcode, msg_kind, control_index, midi_value, fraction_in,
               wrap_mode, new_method, new_low, new_high,
        output ready
    );
endinterface

interface mcvt_rsp_if;
    logic               valid;
    logic               ready;
    logic [16:0]        fraction_out;
    logic signed [14:0] delta_out;
    logic [13:0]        value_out;
    logic               bad_kind;

    modport source (
        output valid, fraction_out, delta_out, value_out, bad_kind,
        input  ready
    );
    modport sink (
        input  valid, fraction_out, delta_out, value_out, bad_kind,
        output ready
    );
endinterface

// File: rtl/mcvt_div.sv
module mcvt_div #(
    parameter int FRACTION_BITS = mcvt_pkg::FRACTION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [13:0]              i_num,
    input  logic [13:0]              i_den,
    output logic                     o_done,
    output logic [FRACTION_BITS:0]   o_quot
);
    localparam int QW = FRACTION_BITS + 1;
    localparam int NW = 14 + QW + 1;
    localparam int CW = $clog2(QW + 1);

    logic [14:0]   r_rem;
    logic [14:0]   r_dsr;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_zero;
    logic          r_done;

    logic [13:0]   num_c;
    logic [NW-1:0] dividend;
    logic [15:0]   trial;
    logic          take;

    always_comb begin
        num_c    = (i_num > i_den) ? i_den : i_num;
        // round half up: (num * 2^(FB+1) + den) / (2 * den)
        dividend = (NW'(num_c) << QW) + NW'(i_den);
        trial    = {r_rem, r_low[QW-1]};
        take     = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= 15'(dividend >> QW);
            r_low  <= QW'(dividend);
            r_dsr  <= {i_den, 1'b0};
            r_zero <= (i_den == 14'd0);
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= take ? 15'(trial - {1'b0, r_dsr}) : 15'(trial);
            r_low  <= r_low << 1;
            r_quot <= {r_quot[QW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

// File: rtl/mcvt_front.sv
module mcvt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    mcvt_req_if.sink         i_req,
    input  logic             i_pop,
    output logic             o_cmd_valid,
    output mcvt_pkg::t_cmd   o_cmd
);
    mcvt_pkg::t_cmd r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    mcvt_pkg::t_cmd cls;
    logic           push;
    logic           pop;

    always_comb begin
        cls.opcode   = i_req.opcode;
        cls.msg_kind = i_req.msg_kind;
        cls.idx      = i_req.control_index;
        cls.value    = i_req.midi_value;
        cls.frac     = i_req.fraction_in;
        cls.wrap     = i_req.wrap_mode;
        cls.method   = i_req.new_method;
        cls.low      = i_req.new_low;
        cls.high     = i_req.new_high;
        cls.idx_ok   = (i_req.control_index < 15'(mcvt_pkg::TABLE_SIZE));
        cls.nrpn     = (i_req.control_index >= 15'(mcvt_pkg::CC_COUNT));
    end

    assign i_req.ready = i_en && (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wp] <= cls;
    end

endmodule

// File: rtl/mcvt_back.sv
module mcvt_back #(
    parameter int FRACTION_BITS = mcvt_pkg::FRACTION_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [13:0]     i_cfg_data,
    input  logic            i_cmd_valid,
    input  mcvt_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_ready_run,
    mcvt_rsp_if.source      o_rsp
);
    localparam int FW = (FRACTION_BITS + 1 > 17) ? FRACTION_BITS + 1 : 17;
    localparam int PW = FW + 14;
    localparam logic [FW-1:0] ONE_Q = FW'(1) << FRACTION_BITS;
    localparam logic [PW-1:0] HALF_Q = PW'(ONE_Q >> 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_ADD   = 6'b100000
    } t_state;

    function automatic logic [13:0] midpoint(input logic [13:0] lo, input logic [13:0] hi);
        logic [14:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return (hi >= lo) ? 14'((s + 15'd1) >> 1) : 14'(s >> 1);
    endfunction

    function automatic logic signed [14:0] decode_rel(input logic nrpn, input logic [1:0] meth,
                                                       input logic [13:0] v);
        logic signed [14:0] mag;
        logic signed [14:0] res;
        mag = '0;
        case (meth)
            mcvt_pkg::METH_BINOFF: begin
                res = nrpn ? $signed({~v[13], ~v[13], v[12:0]})
                           : $signed({{9{~v[6]}}, v[5:0]});
            end
            mcvt_pkg::METH_SIGNMAG: begin
                if (nrpn) begin
                    mag = $signed({2'b00, v[12:0]});
                    res = v[13] ? -mag : $signed({1'b0, v});
                end else begin
                    mag = $signed({9'd0, v[5:0]});
                    res = v[6] ? -mag : $signed({8'd0, v[6:0]});
                end
            end
            default: begin
                res = nrpn ? $signed({v[13], v}) : $signed({{8{v[6]}}, v[6:0]});
            end
        endcase
        return res;
    endfunction

    t_state r_state;
    logic [14:0] r_clr;
    mcvt_pkg::t_entry r_mem [mcvt_pkg::TABLE_SIZE];
    mcvt_pkg::t_entry r_rd;
    mcvt_pkg::t_cmd   r_cmd;
    logic [13:0] r_wmin, r_wmax, r_wpos;

    logic r_out_valid;
    logic [16:0] r_out_frac;
    logic signed [14:0] r_out_delta;
    logic [13:0] r_out_value;
    logic r_out_bad;

    logic [13:0]   r_lo, r_hi, r_span;
    logic [FW-1:0] r_fc;
    logic          r_tgt_wheel;
    logic [PW-1:0] r_prod;

    // lookup stage decisions
    logic l_go_div, l_go_mul, l_wr, l_wheel_wr, l_tgt_wheel, l_bad;
    logic [13:0] l_num, l_den, l_wheel_val, l_vo, l_lo, l_hi;
    logic signed [14:0] l_delta;
    mcvt_pkg::t_entry l_went;
    logic [FW-1:0] l_fc;

    mcvt_pkg::t_entry e;
    logic signed [14:0] dec;
    logic signed [16:0] acc, hi17;
    logic [13:0] n_pos, vc, top, set_lo, set_hi;

    logic [PW-1:0] sum_q;
    logic [14:0]   add_v;
    logic [13:0]   fin_v;

    logic div_start, div_done;
    logic [FRACTION_BITS:0] div_q;

    logic mem_we;
    logic [14:0] mem_wa;
    mcvt_pkg::t_entry mem_wd;
    logic rd_en;
    logic [14:0] rd_addr;

    logic [13:0] cfg_min, cfg_max;

    mcvt_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (l_num),
        .i_den   (l_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_ready_run = (r_state != S_CLEAR);
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign rd_en       = o_cmd_pop;
    assign rd_addr     = i_cmd.idx_ok ? i_cmd.idx : 15'd0;

    // relative accumulation and range checks on the looked-up entry
    always_comb begin
        e    = r_rd;
        dec  = decode_rel(r_cmd.nrpn, e.meth, r_cmd.value);
        hi17 = $signed({3'b000, e.hi});
        acc  = $signed({3'b000, e.pos}) + 17'(dec);
        if (r_cmd.wrap && acc > hi17) begin
            acc = acc - hi17;
        end else if (r_cmd.wrap && acc < 17'sd0) begin
            acc = acc + hi17;
        end
        if (acc < 17'sd0) begin
            n_pos = 14'd0;
        end else if (acc > hi17) begin
            n_pos = e.hi;
        end else begin
            n_pos = acc[13:0];
        end
        top    = r_cmd.nrpn ? mcvt_pkg::MAX_NRPN : mcvt_pkg::MAX_CC;
        set_lo = (r_cmd.low >= e.hi) ? 14'd0 : r_cmd.low;
        set_hi = (r_cmd.high <= set_lo || r_cmd.high > top) ? top : r_cmd.high;
        if (r_cmd.method != mcvt_pkg::METH_ABS) begin
            set_lo = 14'd0;
            set_hi = r_cmd.high;
        end
    end

    always_comb begin
        l_go_div    = 1'b0;
        l_go_mul    = 1'b0;
        l_wr        = 1'b0;
        l_wheel_wr  = 1'b0;
        l_wheel_val = r_cmd.value;
        l_tgt_wheel = 1'b0;
        l_bad       = 1'b0;
        l_num       = 14'd0;
        l_den       = 14'd0;
        l_vo        = 14'd0;
        l_delta     = '0;
        l_lo        = e.lo;
        l_hi        = e.hi;
        l_went      = e;
        l_fc        = ({{(FW-17){1'b0}}, r_cmd.frac} > ONE_Q) ? ONE_Q
                                                            : FW'(r_cmd.frac);
        vc          = r_cmd.value;
        case (r_cmd.opcode)
            mcvt_pkg::OP_CONV_IN: begin
                if (r_cmd.msg_kind == mcvt_pkg::KIND_WHEEL) begin
                    l_wheel_wr = 1'b1;
                    l_go_div   = 1'b1;
                    if (vc < r_wmin) vc = r_wmin;
                    if (vc > r_wmax) vc = r_wmax;
                    l_num = vc - r_wmin;
                    l_den = (r_wmax > r_wmin) ? r_wmax - r_wmin : 14'd0;
                end else if (r_cmd.msg_kind == mcvt_pkg::KIND_CC) begin
                    if (r_cmd.idx_ok) begin
                        l_wr     = 1'b1;
                        l_go_div = 1'b1;
                        if (e.meth == mcvt_pkg::METH_ABS) begin
                            l_went.pos = r_cmd.value;
                            if (vc < e.lo) vc = e.lo;
                            if (vc > e.hi) vc = e.hi;
                            l_num = vc - e.lo;
                            l_den = (e.hi > e.lo) ? e.hi - e.lo : 14'd0;
                        end else begin
                            l_went.pos = n_pos;
                            l_num      = n_pos;
                            l_den      = e.hi;
                        end
                    end
                end else if (r_cmd.msg_kind == mcvt_pkg::KIND_NOTE_ON) begin
                    l_go_div = 1'b1;
                    l_num    = r_cmd.value;
                    l_den    = r_cmd.nrpn ? mcvt_pkg::MAX_NRPN : mcvt_pkg::MAX_CC;
                end else if (r_cmd.msg_kind != mcvt_pkg::KIND_NOTE_OFF) begin
                    l_bad = 1'b1;
                end
            end
            mcvt_pkg::OP_MEASURE: begin
                if (r_cmd.msg_kind == mcvt_pkg::KIND_WHEEL) begin
                    l_delta    = $signed({1'b0, r_cmd.value}) - $signed({1'b0, r_wpos});
                    l_wheel_wr = 1'b1;
                end else if (r_cmd.msg_kind == mcvt_pkg::KIND_CC) begin
                    if (r_cmd.idx_ok) begin
                        if (e.meth == mcvt_pkg::METH_ABS) begin
                            l_delta    = $signed({1'b0, r_cmd.value}) - $signed({1'b0, e.pos});
                            l_wr       = 1'b1;
                            l_went.pos = r_cmd.value;
                        end else begin
                            l_delta = dec;
                        end
                    end
                end else if (r_cmd.msg_kind inside {[3'd4:3'd7]}) begin
                    l_bad = 1'b1;
                end
            end
            mcvt_pkg::OP_CONV_OUT: begin
                if (r_cmd.msg_kind == mcvt_pkg::KIND_WHEEL) begin
                    l_go_mul    = 1'b1;
                    l_tgt_wheel = 1'b1;
                    l_lo        = r_wmin;
                    l_hi        = r_wmax;
                end else if (r_cmd.msg_kind == mcvt_pkg::KIND_CC) begin
                    l_go_mul = r_cmd.idx_ok;
                end else if (r_cmd.msg_kind == mcvt_pkg::KIND_NOTE_ON) begin
                    l_vo = mcvt_pkg::MAX_CC;
                end else begin
                    l_bad = 1'b1;
                end
            end
            mcvt_pkg::OP_CENTER: begin
                if (r_cmd.msg_kind == mcvt_pkg::KIND_WHEEL) begin
                    l_wheel_wr  = 1'b1;
                    l_wheel_val = midpoint(r_wmin, r_wmax);
                    l_vo        = l_wheel_val;
                end else if (r_cmd.msg_kind == mcvt_pkg::KIND_CC && r_cmd.idx_ok
                             && e.meth == mcvt_pkg::METH_ABS) begin
                    l_wr       = 1'b1;
                    l_went.pos = midpoint(e.lo, e.hi);
                    l_vo       = l_went.pos;
                end
            end
            mcvt_pkg::OP_SET: begin
                if (r_cmd.idx_ok) begin
                    l_wr        = 1'b1;
                    l_went.meth = r_cmd.method;
                    l_went.lo   = set_lo;
                    l_went.hi   = set_hi;
                    l_went.pos  = midpoint(set_lo, set_hi);
                end
            end
            default: begin
            end
        endcase
    end

    assign div_start = (r_state == S_LOOK) && l_go_div;

    // final convert-out step: low + rounded scaled span, clamped to high
    always_comb begin
        sum_q = r_prod + HALF_Q;
        add_v = {1'b0, r_lo} + 15'(sum_q >> FRACTION_BITS);
        if (r_hi <= r_lo) begin
            fin_v = r_lo;
        end else if (add_v > {1'b0, r_hi}) begin
            fin_v = r_hi;
        end else begin
            fin_v = add_v[13:0];
        end
    end

    // one write port shared by the clearing pass, lookup and convert-out
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cmd.idx;
        mem_wd = l_went;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wa    = r_clr;
                mem_wd.lo = 14'd0;
                mem_wd.meth = mcvt_pkg::METH_ABS;
                if (r_clr < 15'(mcvt_pkg::CC_COUNT)) begin
                    mem_wd.hi  = mcvt_pkg::MAX_CC;
                    mem_wd.pos = mcvt_pkg::CC_RESET;
                end else begin
                    mem_wd.hi  = mcvt_pkg::MAX_NRPN;
                    mem_wd.pos = mcvt_pkg::NRPN_RESET;
                end
            end
            S_LOOK: begin
                mem_we = l_wr;
            end
            S_ADD: begin
                mem_we     = !r_tgt_wheel;
                mem_wd     = r_rd;
                mem_wd.pos = fin_v;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (rd_en)  r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        cfg_min = (i_cfg_data >= r_wmax) ? 14'd0 : i_cfg_data;
        cfg_max = (i_cfg_data <= r_wmin) ? mcvt_pkg::MAX_NRPN : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= 15'd0;
            r_out_valid <= 1'b0;
            r_wmin      <= 14'd0;
            r_wmax      <= mcvt_pkg::MAX_NRPN;
            r_wpos      <= mcvt_pkg::WHEEL_CTR;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_out_valid <= 1'b0;

            // register writes recenter the wheel
            if (i_cfg_we) begin
                if (i_cfg_idx == mcvt_pkg::CFG_WHEEL_MIN) begin
                    r_wmin <= cfg_min;
                    r_wpos <= midpoint(cfg_min, r_wmax);
                end else begin
                    r_wmax <= cfg_max;
                    r_wpos <= midpoint(r_wmin, cfg_max);
                end
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 15'd1;
                    if (r_clr == 15'(mcvt_pkg::TABLE_SIZE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_cmd_pop) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (l_wheel_wr) r_wpos <= l_wheel_val;
                    if (l_go_div) begin
                        r_state <= S_DIV;
                    end else if (l_go_mul) begin
                        r_state <= S_MUL;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_tgt_wheel) r_wpos <= fin_v;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (r_state == S_LOOK) begin
            r_out_frac  <= 17'd0;
            r_out_delta <= l_delta;
            r_out_value <= l_vo;
            r_out_bad   <= l_bad;
            r_lo        <= l_lo;
            r_hi        <= l_hi;
            r_span      <= (l_hi > l_lo) ? l_hi - l_lo : 14'd0;
            r_fc        <= l_fc;
            r_tgt_wheel <= l_tgt_wheel;
        end
        if (r_state == S_DIV && div_done) r_out_frac <= 17'(div_q);
        if (r_state == S_MUL) r_prod <= r_fc * r_span;
        if (r_state == S_ADD) r_out_value <= fin_v;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.fraction_out = r_out_frac;
    assign o_rsp.delta_out    = r_out_delta;
    assign o_rsp.value_out    = r_out_value;
    assign o_rsp.bad_kind     = r_out_bad;

endmodule

// File: rtl/midi_control_value_tracker.sv
// MIDI control value tracker: holds range, encoding method and current value
// for 128 plain controllers and 16384 NRPN controllers plus the pitch wheel,
// and answers one result request per command request. After reset the block
// sweeps its control table once, one entry per cycle, and takes no command
// until the sweep is done; register writes are taken at any time. A command
// that needs a fraction (convert in) goes through the bit-serial divider (one
// quotient bit per cycle); convert out goes through the multiplier and a final
// add, and every other command is bound by the table read ahead of its
// read-modify-write. A two-entry command queue in front keeps taking requests,
// until it is full, while the back end works or a result waits.
module midi_control_value_tracker #(
    parameter int FRACTION_BITS = mcvt_pkg::FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port: index 0 wheel_min, index 1 wheel_max
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [13:0] i_cfg_data,
    mcvt_req_if.sink    i_req,
    mcvt_rsp_if.source  o_rsp
);
    logic           cmd_valid;
    logic           cmd_pop;
    logic           run_en;
    mcvt_pkg::t_cmd cmd;

    // accept and classify, queue up to two commands
    mcvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (run_en),
        .i_req       (i_req),
        .i_pop       (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // table lookup, arithmetic and write-back, then hold the result
    mcvt_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_ready_run (run_en),
        .o_rsp       (o_rsp)
    );

endmodule
